>>> rtl/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types and constants of the go-to-goal controller: register indexes,
// CORDIC arctangent table and the fixed angle and gain constants.
// ----------------------------------------------------------------------------
package gtg_pkg;

  localparam int unsigned CfgIdxW = 3;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t CfgGoalX    = 3'd0;
  localparam cfg_idx_t CfgGoalY    = 3'd1;
  localparam cfg_idx_t CfgLinGain  = 3'd2;
  localparam cfg_idx_t CfgAngGain  = 3'd3;
  localparam cfg_idx_t CfgMaxLin   = 3'd4;
  localparam cfg_idx_t CfgMaxAng   = 3'd5;
  localparam cfg_idx_t CfgTol      = 3'd6;
  localparam cfg_idx_t CfgClampEn  = 3'd7;

  // Angles are signed, 2^-30 rad per LSB
  localparam int unsigned ZW   = 35;
  localparam int unsigned ErrW = 37;
  localparam logic signed [ErrW-1:0] AngPi    = 37'sd3373259426;
  localparam logic signed [ErrW-1:0] AngTwoPi = 37'sd6746518852;

  // 1/K of the CORDIC, Q0.32
  localparam logic [31:0] InvGain = 32'd2608131496;

  localparam logic [31:0] AtanTab [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

endpackage

>>> rtl/gtg_if.sv
// ----------------------------------------------------------------------------
// gtg_if
// Valid/ready channels of the go-to-goal controller: pose in, command out.
// ----------------------------------------------------------------------------
interface gtg_pose_if #(
  parameter int unsigned POSITION_WIDTH = 48
);
  logic                             valid;
  logic                             ready;
  logic signed [POSITION_WIDTH-1:0] pos_x;
  logic signed [POSITION_WIDTH-1:0] pos_y;
  logic signed [15:0]               heading;

  modport source (output valid, output pos_x, output pos_y, output heading, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

interface gtg_cmd_if #(
  parameter int unsigned POSITION_WIDTH = 48
);
  logic                      valid;
  logic                      ready;
  logic signed [15:0]        linear_cmd;
  logic signed [15:0]        angular_cmd;
  logic [POSITION_WIDTH-1:0] goal_distance;
  logic                      arrived;

  modport source (output valid, output linear_cmd, output angular_cmd,
                  output goal_distance, output arrived, input ready);
  modport sink   (input valid, input linear_cmd, input angular_cmd,
                  input goal_distance, input arrived, output ready);
endinterface

>>> rtl/go_to_goal_p_controller.sv
// ----------------------------------------------------------------------------
// go_to_goal_p_controller
// Takes one pose at a time: a new pose is accepted only once the sequencer is
// back in idle. The CORDIC runs one step per cycle, and there is a single shared
// 32x32 multiplier.
// A pose is taken while a finished command still waits in the output register.
// Reset: async active low; configuration registers at their defaults, arrived latch clear.
// ----------------------------------------------------------------------------
module go_to_goal_p_controller #(
  parameter int unsigned POSITION_WIDTH = 48,
  parameter int unsigned CORDIC_STEPS   = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  gtg_pkg::cfg_idx_t         cfg_idx_i,
  input  logic [POSITION_WIDTH-1:0] cfg_data_i,
  gtg_pose_if.sink                  pose_i,
  gtg_cmd_if.source                 cmd_o
);

  localparam int unsigned W  = POSITION_WIDTH;
  // Operands above 60 bits are pre-shifted so the CORDIC stays inside 63 bits
  localparam int unsigned PS = (W > 60) ? (W - 60) : 0;
  localparam int unsigned DW = W - PS + 1;   // goal minus pose
  localparam int unsigned CW = DW + 2;       // CORDIC x/y with gain headroom
  localparam int unsigned IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int unsigned ZW = gtg_pkg::ZW;
  localparam int unsigned EW = gtg_pkg::ErrW;
  localparam logic [63:0] DistMax = (W == 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                              : ((64'd1 << W) - 64'd1);

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;   // goal minus pose
  localparam logic [3:0] ST_PRE   = 4'd2;   // fold left half plane by pi
  localparam logic [3:0] ST_ROT   = 4'd3;   // one CORDIC micro-rotation per cycle
  localparam logic [3:0] ST_MLO   = 4'd4;   // x[31:0] * 1/K, raw heading error
  localparam logic [3:0] ST_MHI   = 4'd5;   // x[hi] * 1/K, wrap error
  localparam logic [3:0] ST_DIST  = 4'd6;   // sum the length, error magnitude
  localparam logic [3:0] ST_SATD  = 4'd7;   // saturate the length
  localparam logic [3:0] ST_LINLO = 4'd8;   // arrival test, d[31:0] * gain
  localparam logic [3:0] ST_LINHI = 4'd9;   // d[39:32] * gain
  localparam logic [3:0] ST_ANG   = 4'd10;  // finish linear, |err| * gain
  localparam logic [3:0] ST_ANGF  = 4'd11;  // finish angular
  localparam logic [3:0] ST_DONE  = 4'd12;  // hand off to the output register

  // Configuration registers
  logic signed [W-1:0] gx_q, gy_q;
  logic [15:0]         lg_q, ag_q;
  logic [14:0]         maxl_q, maxa_q;
  logic [W-2:0]        tol_q;
  logic                clamp_q;
  logic                latch_q;

  // Working registers
  logic [3:0]          state_q, state_d;
  logic signed [W-1:0] px_q, py_q;
  logic signed [15:0]  hd_q;
  logic signed [CW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [IW-1:0]       i_q;
  logic [63:0]         mul_q;
  logic [31:0]         acc_q;
  logic signed [EW-1:0] err_q;
  logic [31:0]         aerr_q;
  logic                neg_q;
  logic [63:0]         draw_q;
  logic [W-1:0]        d_q;
  logic                big_q;
  logic [47:0]         plo_q;
  logic [14:0]         lin_q;
  logic signed [15:0]  ang_q;

  // Output register
  logic                out_valid_q;
  logic signed [15:0]  out_lin_q, out_ang_q;
  logic [W-1:0]        out_dist_q;
  logic                out_arr_q;

  logic pose_fire, out_free, goal_wr;

  assign pose_fire = pose_i.valid && pose_i.ready;
  assign out_free  = !out_valid_q || cmd_o.ready;
  assign goal_wr   = cfg_we_i && (cfg_idx_i == gtg_pkg::CfgGoalX ||
                                  cfg_idx_i == gtg_pkg::CfgGoalY);

  assign pose_i.ready      = (state_q == ST_IDLE);
  assign cmd_o.valid       = out_valid_q;
  assign cmd_o.linear_cmd  = out_lin_q;
  assign cmd_o.angular_cmd = out_ang_q;
  assign cmd_o.goal_distance = out_dist_q;
  assign cmd_o.arrived     = out_arr_q;

  // --------------------------------------------------------------------------
  // Configuration writes. Goal writes also drop the arrived latch; the latch
  // sets in the arrival-test state.
  // --------------------------------------------------------------------------
  logic [63:0] d64;
  logic        arrive_now;

  assign d64        = 64'(d_q);
  assign arrive_now = (d_q <= W'(tol_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q    <= '0;
      gy_q    <= '0;
      lg_q    <= 16'd4096;
      ag_q    <= 16'd1229;
      maxl_q  <= 15'd1229;
      maxa_q  <= 15'd1638;
      tol_q   <= (W-1)'(65536);
      clamp_q <= 1'b1;
      latch_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gtg_pkg::CfgGoalX:   gx_q    <= cfg_data_i;
          gtg_pkg::CfgGoalY:   gy_q    <= cfg_data_i;
          gtg_pkg::CfgLinGain: lg_q    <= cfg_data_i[15:0];
          gtg_pkg::CfgAngGain: ag_q    <= cfg_data_i[15:0];
          gtg_pkg::CfgMaxLin:  maxl_q  <= cfg_data_i[14:0];
          gtg_pkg::CfgMaxAng:  maxa_q  <= cfg_data_i[14:0];
          gtg_pkg::CfgTol:     tol_q   <= cfg_data_i[W-2:0];
          gtg_pkg::CfgClampEn: clamp_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (goal_wr) begin
        latch_q <= 1'b0;
      end else if (state_q == ST_LINLO && arrive_now) begin
        latch_q <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier: operands picked by state, product registered.
  // --------------------------------------------------------------------------
  logic [63:0] cx64;
  logic [31:0] mul_a, mul_b;

  assign cx64 = 64'(x_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MLO: begin
        mul_a = cx64[31:0];
        mul_b = gtg_pkg::InvGain;
      end
      ST_MHI: begin
        mul_a = cx64[63:32];
        mul_b = gtg_pkg::InvGain;
      end
      ST_LINLO: begin
        mul_a = d64[31:0];
        mul_b = 32'(lg_q);
      end
      ST_LINHI: begin
        mul_a = 32'(d64[39:32]);
        mul_b = 32'(lg_q);
      end
      ST_ANG: begin
        mul_a = aerr_q;
        mul_b = 32'(ag_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  // Goal minus pose after the floor pre-shift
  logic signed [DW-1:0] dx, dy;
  assign dx = DW'(gx_q >>> PS) - DW'(px_q >>> PS);
  assign dy = DW'(gy_q >>> PS) - DW'(py_q >>> PS);

  // CORDIC micro-rotation: drive y toward zero, accumulate the angle
  logic signed [CW-1:0] xs, ys, x_rot, y_rot;
  logic signed [ZW-1:0] z_rot, atan_z, z_pi;
  assign xs     = x_q >>> i_q;
  assign ys     = y_q >>> i_q;
  assign atan_z = signed'(ZW'(gtg_pkg::AtanTab[5'(i_q)]));
  assign z_pi   = ZW'(gtg_pkg::AngPi);

  always_comb begin
    if (y_q < 0) begin
      x_rot = x_q - ys;
      y_rot = y_q + xs;
      z_rot = z_q - atan_z;
    end else begin
      x_rot = x_q + ys;
      y_rot = y_q - xs;
      z_rot = z_q + atan_z;
    end
  end

  // Heading error in 2^-30 rad: heading Q3.13 scaled by 2^17
  logic signed [EW-1:0] err_raw, err_wrap, err_neg;
  assign err_raw = EW'(z_q) - (EW'(hd_q) <<< 17);

  always_comb begin
    if (err_q > gtg_pkg::AngPi) begin
      err_wrap = err_q - gtg_pkg::AngTwoPi;
    end else if (err_q <= -gtg_pkg::AngPi) begin
      err_wrap = err_q + gtg_pkg::AngTwoPi;
    end else begin
      err_wrap = err_q;
    end
  end
  assign err_neg = -err_q;

  // Length: restore the pre-shift with saturation, then clip to the port width
  logic        pre_ovf;
  logic [63:0] d_pre, d_clip;
  assign pre_ovf = (PS != 0) && ((draw_q >> (64 - PS)) != 64'd0);
  assign d_pre   = pre_ovf ? 64'hFFFF_FFFF_FFFF_FFFF : (draw_q << PS);
  assign d_clip  = (d_pre > DistMax) ? DistMax : d_pre;

  // Linear command: round(d * gain / 2^16), clamp, saturate
  logic [56:0] lin_sum;
  logic [40:0] lm_raw, lm_clamp;
  logic [14:0] lin_next;
  assign lin_sum = {mul_q[24:0], 32'd0} + 57'(plo_q) + 57'd32768;

  always_comb begin
    if (big_q) begin
      lm_raw = (lg_q != 16'd0) ? '1 : '0;
    end else begin
      lm_raw = lin_sum[56:16];
    end
    lm_clamp = (clamp_q && lm_raw > 41'(maxl_q)) ? 41'(maxl_q) : lm_raw;
    lin_next = (lm_clamp > 41'd32767) ? 15'h7FFF : lm_clamp[14:0];
  end

  // Angular command: round(|err| * gain / 2^30), clamp, saturate, sign
  logic [18:0] am_raw, am_clamp, am_lim, am_sat;
  logic [49:0] ang_sum;
  logic signed [15:0] ang_next;
  assign ang_sum = 50'(mul_q[47:0]) + 50'(32'h2000_0000);
  assign am_raw  = ang_sum[48:30];

  always_comb begin
    am_clamp = (clamp_q && am_raw > 19'(maxa_q)) ? 19'(maxa_q) : am_raw;
    am_lim   = neg_q ? 19'd32768 : 19'd32767;
    am_sat   = (am_clamp > am_lim) ? am_lim : am_clamp;
    ang_next = neg_q ? -signed'(am_sat[15:0]) : signed'(am_sat[15:0]);
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (pose_fire) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_PRE;
      ST_PRE:   state_d = ST_ROT;
      ST_ROT:   if (i_q == IW'(CORDIC_STEPS - 1)) state_d = ST_MLO;
      ST_MLO:   state_d = ST_MHI;
      ST_MHI:   state_d = ST_DIST;
      ST_DIST:  state_d = ST_SATD;
      ST_SATD:  state_d = ST_LINLO;
      ST_LINLO: state_d = ST_LINHI;
      ST_LINHI: state_d = ST_ANG;
      ST_ANG:   state_d = ST_ANGF;
      ST_ANGF:  state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PRE) begin
        i_q <= '0;
      end else if (state_q == ST_ROT) begin
        i_q <= i_q + IW'(1);
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (pose_fire) begin
          px_q <= pose_i.pos_x;
          py_q <= pose_i.pos_y;
          hd_q <= pose_i.heading;
        end
      end
      ST_LOAD: begin
        x_q <= CW'(dx);
        y_q <= CW'(dy);
      end
      ST_PRE: begin
        // Fold a left-half-plane vector by pi so the CORDIC converges
        if (x_q < 0) begin
          x_q <= -x_q;
          y_q <= -y_q;
          z_q <= (y_q >= 0) ? z_pi : -z_pi;
        end else begin
          z_q <= '0;
        end
      end
      ST_ROT: begin
        x_q <= x_rot;
        y_q <= y_rot;
        z_q <= z_rot;
      end
      ST_MLO: begin
        err_q <= err_raw;
      end
      ST_MHI: begin
        acc_q <= mul_q[63:32];
        err_q <= err_wrap;
      end
      ST_DIST: begin
        draw_q <= mul_q + 64'(acc_q);
        neg_q  <= err_q < 0;
        aerr_q <= (err_q < 0) ? err_neg[31:0] : err_q[31:0];
      end
      ST_SATD: begin
        d_q <= W'(d_clip);
      end
      ST_LINLO: begin
        big_q <= (d64[63:40] != 24'd0);
      end
      ST_LINHI: begin
        plo_q <= mul_q[47:0];
      end
      ST_ANG: begin
        lin_q <= lin_next;
      end
      ST_ANGF: begin
        ang_q <= ang_next;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: hold the transaction until taken; zero the commands while
  // the arrived latch is set.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (cmd_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_lin_q  <= latch_q ? 16'sd0 : signed'({1'b0, lin_q});
      out_ang_q  <= latch_q ? 16'sd0 : ang_q;
      out_dist_q <= d_q;
      out_arr_q  <= latch_q;
    end
  end

`ifndef NO_ASSERTIONS
  // A command only appears after the sequencer hands one off
  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("command valid without hand-off");

  // An accepted pose keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pose_fire |=> (state_q == ST_LOAD) && !pose_i.ready)
    else $error("pose accepted but sequencer not started");

  // Arrived commands carry zero speed and turn rate
  a_arrived_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_arr_q) |-> (out_lin_q == 16'sd0 && out_ang_q == 16'sd0))
    else $error("arrived command not zero");

  // The hand-off completes whenever the output register can take it
  a_done_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("hand-off stalled with a free output register");
`endif

endmodule
